// ===== sv/mie_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the modular inverse block.
// No dependencies.
package mie_pkg;

  localparam int unsigned MIE_WIDTH = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_REDUCE,
    S_FIX
  } mie_state_t;

  typedef struct packed {
    logic start;
  } mie_unit_ctl_t;

  typedef struct packed {
    logic done;
  } mie_unit_sts_t;

endpackage

// ===== sv/modular_inverse_ext_euclid.sv =====
`timescale 1ns / 1ps
// Modular inverse by extended Euclid; one shared bit-serial divide/MAC unit.
// Each Euclid step passes through check, the divider and update; after the last
// step (or straight from check for a zero modulus) reduce and fix give the result.
// busy is high from the start transfer until the result; the done strobe lasts
// one cycle and the receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle.
module modular_inverse_ext_euclid import mie_pkg::*; #(
  parameter int unsigned WIDTH = MIE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] value,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] inverse,
  output logic             exists,
  output logic [WIDTH-1:0] divisor
);

  mie_state_t state, state_next;

  logic [WIDTH-1:0] r_prev;
  logic [WIDTH-1:0] r_cur;
  logic [WIDTH-1:0] m_prev;
  logic [WIDTH-1:0] m_cur;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] g;
  logic [WIDTH-1:0] red;
  logic             neg;

  mie_unit_ctl_t    uctl;
  mie_unit_sts_t    usts;
  logic [WIDTH-1:0] urem;
  logic [WIDTH-1:0] uprod;
  logic             accept;

  assign accept = start && !busy;

  mie_step_unit #(.WIDTH(WIDTH)) u_step (
    .clk       (clk),
    .rst       (rst),
    .ctl       (uctl),
    .dividend  (r_prev),
    .divisor   (r_cur),
    .coef      (m_cur),
    .sts       (usts),
    .remainder (urem),
    .product   (uprod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_CHECK;
      S_CHECK:  state_next = (r_cur == '0) ? S_REDUCE : S_DIV;
      S_DIV:    if (usts.done) state_next = S_UPDATE;
      S_UPDATE: state_next = (urem == '0) ? S_REDUCE : S_CHECK;
      S_REDUCE: state_next = S_FIX;
      S_FIX:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    uctl.start = 1'b0;
    unique case (state)
      S_IDLE:  busy = 1'b0;
      S_CHECK: uctl.start = (r_cur != '0);
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_prev <= value;
      r_cur  <= modulus;
      mod_q  <= modulus;
      m_prev <= WIDTH'(1);
      m_cur  <= '0;
      neg    <= 1'b1;
      g      <= '0;
    end else if (state == S_UPDATE) begin
      if (urem == '0) begin
        // hold m_cur and parity as the Bezout coefficient
        g <= r_cur;
      end else begin
        m_prev <= m_cur;
        m_cur  <= uprod + m_prev;
        r_prev <= r_cur;
        r_cur  <= urem;
        neg    <= ~neg;
      end
    end else if (state == S_REDUCE) begin
      red <= (m_cur >= mod_q) ? m_cur - mod_q : m_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIX) begin
      exists  <= (g == WIDTH'(1));
      divisor <= g;
      if (g != WIDTH'(1)) begin
        inverse <= '0;
      end else if (neg && red != '0) begin
        inverse <= mod_q - red;
      end else begin
        inverse <= red;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FIX);
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_exists_gcd: assert property (@(posedge clk) disable iff (rst)
    done |-> (exists == (divisor == WIDTH'(1))))
    else $error("exists flag disagrees with gcd");

  a_no_inv: assert property (@(posedge clk) disable iff (rst)
    done && !exists |-> inverse == '0)
    else $error("inverse reported without gcd of one");

  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    usts.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

endmodule

// ===== sv/mie_step_unit.sv =====
`timescale 1ns / 1ps
// Bit-serial divide with a coefficient shift-add: one quotient bit per cycle.
// Depends on mie_pkg for the control and status structs.
module mie_step_unit import mie_pkg::*; #(
  parameter int unsigned WIDTH = MIE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  mie_unit_ctl_t     ctl,
  input  logic [WIDTH-1:0]  dividend,
  input  logic [WIDTH-1:0]  divisor,
  input  logic [WIDTH-1:0]  coef,
  output mie_unit_sts_t     sts,
  output logic [WIDTH-1:0]  remainder,
  output logic [WIDTH-1:0]  product
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] cf;
  logic [CW-1:0]    cnt;
  logic             run;
  logic             done;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             qbit;

  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    qbit    = ~diff[WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= CW'(WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
      acc <= '0;
      dvs <= divisor;
      cf  <= coef;
    end else if (run) begin
      rem <= qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], 1'b0};
      // product never exceeds the next coefficient, so WIDTH bits hold it
      acc <= {acc[WIDTH-2:0], 1'b0} + (qbit ? cf : '0);
    end
  end

  assign sts.done  = done;
  assign remainder = rem;
  assign product   = acc;

endmodule
